// ===== design/bmu_pkg.sv =====
package bmu_pkg;

    localparam int MAX_LINE = 2048;
    localparam int LINE_AW  = $clog2(MAX_LINE);

    localparam int PIX_W    = 8;
    localparam int VALUE_W  = PIX_W + 1;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int COL_W    = WIDTH_W + 1;
    localparam int ROW_W    = HEIGHT_W + 1;
    localparam int CFG_W    = HEIGHT_W;
    localparam int CFG_IDX_W = 2;

    localparam int WIN_TAPS = 9;
    localparam int SUM_W    = $clog2(WIN_TAPS * ((1 << PIX_W) - 1) + 1);

    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'(((1 << DIV9_SHIFT) + 8) / 9);
    localparam int PROD_W = SUM_W + DIV9_MUL_W;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(2046);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(2046);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_FILTER_MODE  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_MEAN    = 1'b0,
        MODE_UNSHARP = 1'b1
    } filter_mode_t;

    typedef struct packed {
        logic               rd_en;
        logic [LINE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [LINE_AW-1:0] wr_addr;
        logic [PIX_W-1:0]   wr_upper;
        logic [PIX_W-1:0]   wr_lower;
    } line_ctrl_t;

    // Floor division by nine through a rounded-up reciprocal; exact for any window sum.
    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        begin
            prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
            return prod[DIV9_SHIFT +: PIX_W];
        end
    endfunction

endpackage

// ===== design/bmu_line_buf.sv =====
module bmu_line_buf (
    input  logic                           clk,
    input  bmu_pkg::line_ctrl_t            ctrl,
    output logic [bmu_pkg::PIX_W-1:0]      rd_upper,
    output logic [bmu_pkg::PIX_W-1:0]      rd_lower
);

    logic [bmu_pkg::PIX_W-1:0] upper_mem [bmu_pkg::MAX_LINE];
    logic [bmu_pkg::PIX_W-1:0] lower_mem [bmu_pkg::MAX_LINE];
    logic [bmu_pkg::PIX_W-1:0] upper_q_reg;
    logic [bmu_pkg::PIX_W-1:0] lower_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            upper_mem[ctrl.wr_addr] <= ctrl.wr_upper;
            lower_mem[ctrl.wr_addr] <= ctrl.wr_lower;
        end
    end

    // A column rewritten at the same edge that reads it passes the new word straight through.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            if (ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr))
            begin
                upper_q_reg <= ctrl.wr_upper;
                lower_q_reg <= ctrl.wr_lower;
            end
            else
            begin
                upper_q_reg <= upper_mem[ctrl.rd_addr];
                lower_q_reg <= lower_mem[ctrl.rd_addr];
            end
        end
    end

    assign rd_upper = upper_q_reg;
    assign rd_lower = lower_q_reg;

endmodule

// ===== design/box_mean_unsharp_3x3_core.sv =====
// 3x3 box mean and unsharp mask over a raster stream of 8-bit gray pixels.
// Input channel: in_valid/in_ready with pixel. One word is taken for every scan
// position of image_height+2 rows of image_width+2 columns; the last two columns
// of each row and the last two rows are padding, where the pixel is ignored.
// Output channel: out_valid/out_ready with value and last_of_image. A word is
// given for each 3x3 window once it is complete, anchored at its top-left pixel;
// last_of_image marks the final anchor of the image. The scan then starts the next
// image at once.
// An accepted pixel passes through the middle stage and the output register to
// its result word. Throughput is one pixel per cycle while the receiver keeps up,
// as set by the line store read and write ports, each used once per pixel.
// Configuration is written through cfg_write/cfg_index/cfg_data, by the user only
// while the block is idle, which it does not enforce. Reset clears the scan
// position, the window and both pipeline stages and loads the default registers;
// the line stores are not cleared. When the receiver stalls, the result word holds,
// the middle stage holds, and in_ready drops until the output register frees up.
module box_mean_unsharp_3x3_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bmu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bmu_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bmu_pkg::PIX_W-1:0]            pixel,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bmu_pkg::VALUE_W-1:0]   value,
    output logic                                 last_of_image
);

    logic [bmu_pkg::WIDTH_W-1:0]  width_reg;
    logic [bmu_pkg::HEIGHT_W-1:0] height_reg;
    bmu_pkg::filter_mode_t        mode_reg;

    logic [bmu_pkg::ROW_W-1:0] row_reg;
    logic [bmu_pkg::ROW_W-1:0] row_next;
    logic [bmu_pkg::COL_W-1:0] col_reg;
    logic [bmu_pkg::COL_W-1:0] col_next;

    logic                        s1_valid_reg;
    logic [bmu_pkg::PIX_W-1:0]   s1_pix_reg;
    logic                        s1_emit_reg;
    logic                        s1_last_reg;
    logic [bmu_pkg::LINE_AW-1:0] s1_addr_reg;

    logic [bmu_pkg::PIX_W-1:0] win_reg [6];

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [bmu_pkg::VALUE_W-1:0] value_reg;
    logic                               last_reg;

    logic                        accept;
    logic                        s1_adv;
    logic [bmu_pkg::ROW_W-1:0]   row_end;
    logic [bmu_pkg::COL_W-1:0]   col_end;
    logic                        in_image;
    logic                        emit;
    logic                        last;
    logic [bmu_pkg::PIX_W-1:0]   pix_masked;
    logic [bmu_pkg::PIX_W-1:0]   rd_upper;
    logic [bmu_pkg::PIX_W-1:0]   rd_lower;
    logic [bmu_pkg::SUM_W-1:0]   win_sum;
    logic [bmu_pkg::PIX_W-1:0]   mean;
    logic signed [bmu_pkg::VALUE_W-1:0] result;
    bmu_pkg::line_ctrl_t         line_ctrl;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bmu_pkg::WIDTH_RESET;
            height_reg <= bmu_pkg::HEIGHT_RESET;
            mode_reg   <= bmu_pkg::MODE_MEAN;
        end
        else if (cfg_write)
        begin
            case (bmu_pkg::cfg_index_t'(cfg_index))
                bmu_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[bmu_pkg::WIDTH_W-1:0];
                bmu_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[bmu_pkg::HEIGHT_W-1:0];
                bmu_pkg::CFG_FILTER_MODE:  mode_reg   <= bmu_pkg::filter_mode_t'(cfg_data[0]);
                default:                   ;
            endcase
        end
    end

    // Scan position and per-word flags, worked out as the word is taken.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign row_end  = bmu_pkg::ROW_W'(height_reg) + bmu_pkg::ROW_W'(1);
    assign col_end  = bmu_pkg::COL_W'(width_reg) + bmu_pkg::COL_W'(1);
    assign in_image = (row_reg < bmu_pkg::ROW_W'(height_reg))
                   && (col_reg < bmu_pkg::COL_W'(width_reg));
    assign pix_masked = in_image ? pixel : '0;
    assign emit = (row_reg >= bmu_pkg::ROW_W'(2)) && (col_reg >= bmu_pkg::COL_W'(2))
               && (row_reg <= row_end) && (col_reg <= col_end);
    assign last = (row_reg == row_end) && (col_reg == col_end);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_reg >= col_end)
            begin
                col_next = '0;
                row_next = (row_reg >= row_end) ? '0 : row_reg + bmu_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + bmu_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix_masked;
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_addr_reg <= col_reg[bmu_pkg::LINE_AW-1:0];
        end
    end

    // The two rows above are read as the word is taken and rewritten as it leaves.
    always_comb
    begin
        line_ctrl.rd_en    = accept;
        line_ctrl.rd_addr  = col_reg[bmu_pkg::LINE_AW-1:0];
        line_ctrl.wr_en    = s1_adv;
        line_ctrl.wr_addr  = s1_addr_reg;
        line_ctrl.wr_upper = rd_lower;
        line_ctrl.wr_lower = s1_pix_reg;
    end

    bmu_line_buf u_line_buf (
        .clk      (clk),
        .ctrl     (line_ctrl),
        .rd_upper (rd_upper),
        .rd_lower (rd_lower)
    );

    // Window sum, mean and unsharp difference.
    always_comb
    begin
        win_sum = bmu_pkg::SUM_W'(rd_upper) + bmu_pkg::SUM_W'(rd_lower)
                + bmu_pkg::SUM_W'(s1_pix_reg);
        for (int k = 0; k < 6; k++)
        begin
            win_sum = win_sum + bmu_pkg::SUM_W'(win_reg[k]);
        end
    end

    assign mean = bmu_pkg::div9(win_sum);

    always_comb
    begin
        case (mode_reg)
            bmu_pkg::MODE_UNSHARP: result = $signed({1'b0, win_reg[0]}) - $signed({1'b0, mean});
            default:               result = $signed({1'b0, mean});
        endcase
    end

    // The window shifts by one column for every word, result or not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= rd_upper;
            win_reg[4] <= rd_lower;
            win_reg[5] <= s1_pix_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_emit_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            value_reg <= result;
            last_reg  <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign value         = value_reg;
    assign last_of_image = last_reg;

`ifndef ASSERT_OFF
    // A stalled result word holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready)
        |=> (out_valid_reg && $stable(value_reg) && $stable(last_reg)))
        else $error("result word changed while stalled");

    // In mean mode the result word is never negative.
    a_mean_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (mode_reg == bmu_pkg::MODE_MEAN)) |-> !value_reg[bmu_pkg::VALUE_W-1])
        else $error("negative result word in mean mode");

    // A stalled middle stage keeps its word.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("middle stage lost a word while stalled");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET  = 1150;

    typedef struct {
        logic signed [bmu_pkg::VALUE_W-1:0] value;
        logic                               last;
    } result_word_t;

    typedef enum int {
        FILL_UNIFORM,
        FILL_RAILS,
        FILL_BRIGHT,
        FILL_DARK,
        FILL_PEAK,
        FILL_NOTCH
    } fill_t;

    // Tracks the scan, both line stores and the window, and queues the word each
    // accepted pixel should produce.
    class box_window_tracker;
        logic [bmu_pkg::PIX_W-1:0] upper_row [bmu_pkg::MAX_LINE];
        logic [bmu_pkg::PIX_W-1:0] lower_row [bmu_pkg::MAX_LINE];
        logic [bmu_pkg::PIX_W-1:0] window [6];
        int                        row;
        int                        col;
        int                        width;
        int                        height;
        bmu_pkg::filter_mode_t     mode;
        result_word_t              pending [$];
        int                        failures;

        function new();
            foreach (upper_row[i])
            begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            row      = 0;
            col      = 0;
            width    = int'(bmu_pkg::WIDTH_RESET);
            height   = int'(bmu_pkg::HEIGHT_RESET);
            mode     = bmu_pkg::MODE_MEAN;
            failures = 0;
        endfunction

        function void set_reg(bmu_pkg::cfg_index_t idx, logic [bmu_pkg::CFG_W-1:0] data);
            case (idx)
                bmu_pkg::CFG_IMAGE_WIDTH:  width = int'(data[bmu_pkg::WIDTH_W-1:0]);
                bmu_pkg::CFG_IMAGE_HEIGHT: height = int'(data[bmu_pkg::HEIGHT_W-1:0]);
                bmu_pkg::CFG_FILTER_MODE:  mode = bmu_pkg::filter_mode_t'(data[0]);
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [bmu_pkg::PIX_W-1:0] px);
            int           idx;
            int           p;
            int           a;
            int           b;
            int           total;
            int           mean;
            int           diff;
            result_word_t word;
            idx = col % bmu_pkg::MAX_LINE;
            p = (row < height && col < width) ? int'(px) : 0;
            a = int'(upper_row[idx]);
            b = int'(lower_row[idx]);
            if (row >= 2 && col >= 2 && row <= height + 1 && col <= width + 1)
            begin
                total = a + b + p;
                foreach (window[k])
                    total += int'(window[k]);
                mean = total / bmu_pkg::WIN_TAPS;
                diff = (mode == bmu_pkg::MODE_UNSHARP) ? int'(window[0]) - mean : mean;
                word.value = diff[bmu_pkg::VALUE_W-1:0];
                word.last  = (row == height + 1 && col == width + 1);
                pending.push_back(word);
            end
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = a[bmu_pkg::PIX_W-1:0];
            window[4] = b[bmu_pkg::PIX_W-1:0];
            window[5] = p[bmu_pkg::PIX_W-1:0];
            upper_row[idx] = b[bmu_pkg::PIX_W-1:0];
            lower_row[idx] = p[bmu_pkg::PIX_W-1:0];
            if (col >= width + 1)
            begin
                col = 0;
                row = (row >= height + 1) ? 0 : row + 1;
            end
            else
            begin
                col++;
            end
        endfunction

        function void check_word(logic signed [bmu_pkg::VALUE_W-1:0] got_value, logic got_last);
            result_word_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected word: value %0d, last_of_image %0b", got_value, got_last);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got_value !== want.value)
            begin
                $error("value: expected %0d, got %0d", want.value, got_value);
                failures++;
            end
            if (got_last !== want.last)
            begin
                $error("last_of_image: expected %0b, got %0b", want.last, got_last);
                failures++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               cfg_write = 1'b0;
    logic [bmu_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [bmu_pkg::CFG_W-1:0]          cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [bmu_pkg::PIX_W-1:0]          pixel = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [bmu_pkg::VALUE_W-1:0] value;
    logic                               last_of_image;

    box_window_tracker tracker = new();
    bit                tx_steady = 1'b0;
    bit                rx_steady = 1'b0;
    int                cycle_count = 0;
    int                pixels_sent = 0;

    box_mean_unsharp_3x3_core uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 1;
        if (r < 90)
            return $urandom_range(2, 4);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [bmu_pkg::PIX_W-1:0] fill_value(fill_t fill, int r, int c);
        case (fill)
            FILL_RAILS:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_BRIGHT: return bmu_pkg::PIX_W'($urandom_range(240, 255));
            FILL_DARK:   return bmu_pkg::PIX_W'($urandom_range(0, 15));
            FILL_PEAK:   return (r == 0 && c == 0) ? 8'hFF : 8'h00;
            FILL_NOTCH:  return (r == 0 && c == 0) ? 8'h00 : 8'hFF;
            default:     return bmu_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_word(value, last_of_image);
            if ($urandom_range(0, 299) == 0)
                rx_steady = !rx_steady;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic push_pixel(input logic [bmu_pkg::PIX_W-1:0] px);
        int gap;
        in_valid <= 1'b1;
        pixel    <= px;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        tracker.take_pixel(px);
        pixels_sent++;
        if ($urandom_range(0, 299) == 0)
            tx_steady = !tx_steady;
        gap = (!tx_steady && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Words at scan positions that give no result never come out, so the task also
    // lets the pipeline drain before the registers may change.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bmu_pkg::cfg_index_t idx, input int data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[bmu_pkg::CFG_W-1:0];
        @(posedge clk);
        tracker.set_reg(idx, data[bmu_pkg::CFG_W-1:0]);
    endtask

    task automatic configure(input int w, input int h, input bmu_pkg::filter_mode_t m);
        settle();
        write_reg(bmu_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(bmu_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(bmu_pkg::CFG_FILTER_MODE, int'(m));
        cfg_write <= 1'b0;
    endtask

    task automatic retune(input bmu_pkg::cfg_index_t idx, input int data);
        settle();
        write_reg(idx, data);
        cfg_write <= 1'b0;
    endtask

    // Sends one full scan, padding included, until the scan wraps to the next image.
    // The width stays fixed inside a scan so that no unwritten line store entry is used.
    task automatic send_image(input fill_t fill, input int split_at);
        int n;
        n = 0;
        do
        begin
            if (n == split_at)
            begin
                if ($urandom_range(0, 1))
                    retune(bmu_pkg::CFG_FILTER_MODE, tracker.mode == bmu_pkg::MODE_MEAN ?
                           int'(bmu_pkg::MODE_UNSHARP) : int'(bmu_pkg::MODE_MEAN));
                else
                    retune(bmu_pkg::CFG_IMAGE_HEIGHT, $urandom_range(1, 12));
            end
            push_pixel(fill_value(fill, tracker.row, tracker.col));
            n++;
        end
        while (tracker.row != 0 || tracker.col != 0);
    endtask

    initial
    begin
        int    w;
        int    h;
        int    r;
        int    split;
        fill_t fill;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(1, 1, bmu_pkg::MODE_MEAN);
        send_image(FILL_PEAK, -1);
        send_image(FILL_RAILS, -1);
        retune(bmu_pkg::CFG_FILTER_MODE, int'(bmu_pkg::MODE_UNSHARP));
        send_image(FILL_PEAK, -1);
        configure(2, 2, bmu_pkg::MODE_UNSHARP);
        send_image(FILL_NOTCH, -1);
        configure(2, 2, bmu_pkg::MODE_MEAN);
        send_image(FILL_NOTCH, 7);
        configure(0, 3, bmu_pkg::MODE_MEAN);
        send_image(FILL_UNIFORM, -1);
        configure(3, 0, bmu_pkg::MODE_UNSHARP);
        send_image(FILL_UNIFORM, -1);

        while (pixels_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                w = $urandom_range(1, 12);
            else if (r < 95)
                w = $urandom_range(13, 64);
            else
                w = $urandom_range(65, 200);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
            if ($urandom_range(0, 39) == 0)
                w = 0;
            else if ($urandom_range(0, 39) == 0)
                h = 0;
            configure(w, h, bmu_pkg::filter_mode_t'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
            begin
                if (pixels_sent < ITEM_TARGET)
                begin
                    fill  = fill_t'($urandom_range(0, 3));
                    split = -1;
                    if ($urandom_range(0, 4) == 0)
                        split = $urandom_range(1,
                                (tracker.width + 2) * (tracker.height + 2) - 1);
                    send_image(fill, split);
                end
            end
        end

        settle();
        if (tracker.failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bmu_pkg.sv
design/bmu_line_buf.sv
design/box_mean_unsharp_3x3_core.sv
bench/tb.sv
